// ===== hw/rtl/cgss_pkg.sv =====
package cgss_pkg;

    localparam int PHASE_STEPS = 16;
    localparam int PHASE_W     = $clog2(PHASE_STEPS);
    localparam int ANGLE_W     = 8;
    localparam int POS_W       = 11;  // signed working width for positions

    localparam int REST_POS    = 90;
    localparam int FULL_ANGLE  = 180;
    localparam int PERIOD_MIN  = 45;
    localparam int PERIOD_STEP = 15;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 7;

    typedef enum logic [2:0] {
        MODE_REST       = 3'd0,
        MODE_STAND      = 3'd1,
        MODE_FWD_LEFT   = 3'd2,
        MODE_FWD        = 3'd3,
        MODE_FWD_RIGHT  = 3'd4,
        MODE_BACK_LEFT  = 3'd5,
        MODE_BACK       = 3'd6,
        MODE_BACK_RIGHT = 3'd7
    } mode_t;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_STAND_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TORSO_SWING  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_SWING   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_MAX     = 3'd4;

    // command characters
    localparam logic [7:0] CMD_FWD        = 8'h46; // F
    localparam logic [7:0] CMD_BACK       = 8'h42; // B
    localparam logic [7:0] CMD_FWD_LEFT   = 8'h47; // G
    localparam logic [7:0] CMD_FWD_RIGHT  = 8'h49; // I
    localparam logic [7:0] CMD_BACK_LEFT  = 8'h48; // H
    localparam logic [7:0] CMD_BACK_RIGHT = 8'h4A; // J
    localparam logic [7:0] CMD_STAND_L    = 8'h4C; // L
    localparam logic [7:0] CMD_STAND_R    = 8'h52; // R
    localparam logic [7:0] CMD_STAND_S    = 8'h53; // S
    localparam logic [7:0] CMD_DIGIT_0    = 8'h30; // 0, also stand
    localparam logic [7:0] CMD_DIGIT_1    = 8'h31;
    localparam logic [7:0] CMD_DIGIT_9    = 8'h39;
    localparam logic [7:0] CMD_FAST       = 8'h71; // q

    typedef struct packed {
        logic [6:0] stand_offset;
        logic [5:0] torso_swing;
        logic [5:0] turn_swing;
        logic [6:0] step_min;
        logic [6:0] step_max;
    } cfg_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] torso;
        logic [ANGLE_W-1:0] front_left;
        logic [ANGLE_W-1:0] front_right;
        logic [ANGLE_W-1:0] rear_left;
        logic [ANGLE_W-1:0] rear_right;
    } angles_t;

    function automatic logic [7:0] wave_at(input logic [PHASE_W-1:0] idx);
        logic [7:0] w;
        case (idx)
            4'd0:    w = 8'd0;
            4'd1:    w = 8'd10;
            4'd2:    w = 8'd38;
            4'd3:    w = 8'd80;
            4'd4:    w = 8'd128;
            4'd5:    w = 8'd176;
            4'd6:    w = 8'd218;
            4'd7:    w = 8'd245;
            4'd8:    w = 8'd255;
            4'd9:    w = 8'd245;
            4'd10:   w = 8'd218;
            4'd11:   w = 8'd176;
            4'd12:   w = 8'd128;
            4'd13:   w = 8'd80;
            4'd14:   w = 8'd38;
            4'd15:   w = 8'd10;
            default: w = 8'd0;
        endcase
        return w;
    endfunction

    function automatic logic [ANGLE_W-1:0] clamp_angle(input logic signed [POS_W-1:0] v);
        logic [ANGLE_W-1:0] a;
        if (v < 0) begin
            a = '0;
        end else if (v > POS_W'(FULL_ANGLE)) begin
            a = ANGLE_W'(FULL_ANGLE);
        end else begin
            a = v[ANGLE_W-1:0];
        end
        return a;
    endfunction

endpackage

// ===== hw/rtl/cgss_angle_calc.sv =====
module cgss_angle_calc (
    input  cgss_pkg::cfg_t                   cfg,
    input  cgss_pkg::mode_t                  mode,
    input  logic [cgss_pkg::PHASE_W-1:0]     phase,
    output cgss_pkg::angles_t                angles
);

    localparam int W = cgss_pkg::POS_W;

    logic [7:0]          w0;
    logic [7:0]          w4;
    logic [7:0]          w12;
    logic [6:0]          span;
    logic [14:0]         prod4;
    logic [14:0]         prod12;
    logic signed [W-1:0] walk4;
    logic signed [W-1:0] walk12;
    logic signed [W-1:0] stand_pos;
    logic [7:0]          limb4;
    logic [7:0]          limb12;
    logic [6:0]          swing2;
    logic [7:0]          gain;
    logic [15:0]         tprod;
    logic signed [W-1:0] tbase;
    logic signed [W-1:0] tpos;
    logic [7:0]          torso;

    assign w0  = cgss_pkg::wave_at(phase);
    assign w4  = cgss_pkg::wave_at(phase + cgss_pkg::PHASE_W'(4));
    assign w12 = cgss_pkg::wave_at(phase + cgss_pkg::PHASE_W'(12));

    // negative span clamps to zero
    assign span   = (cfg.step_max >= cfg.step_min) ? (cfg.step_max - cfg.step_min) : 7'd0;
    assign prod4  = 15'(span) * 15'(w4);
    assign prod12 = 15'(span) * 15'(w12);

    assign walk4  = $signed(W'(cgss_pkg::REST_POS)) + $signed({4'b0, cfg.step_min})
                  + $signed({4'b0, prod4[14:8]});
    assign walk12 = $signed(W'(cgss_pkg::REST_POS)) + $signed({4'b0, cfg.step_min})
                  + $signed({4'b0, prod12[14:8]});
    assign stand_pos = $signed(W'(cgss_pkg::REST_POS)) + $signed({4'b0, cfg.stand_offset});

    always_comb begin
        case (mode)
            cgss_pkg::MODE_REST: begin
                limb4  = 8'(cgss_pkg::REST_POS);
                limb12 = 8'(cgss_pkg::REST_POS);
            end
            cgss_pkg::MODE_STAND: begin
                limb4  = cgss_pkg::clamp_angle(stand_pos);
                limb12 = cgss_pkg::clamp_angle(stand_pos);
            end
            default: begin
                limb4  = cgss_pkg::clamp_angle(walk4);
                limb12 = cgss_pkg::clamp_angle(walk12);
            end
        endcase
    end

    assign swing2 = {cfg.torso_swing, 1'b0};

    always_comb begin
        case (mode)
            cgss_pkg::MODE_FWD_LEFT, cgss_pkg::MODE_BACK_LEFT: begin
                gain  = 8'(swing2) + 8'(cfg.turn_swing);
                tbase = $signed(W'(cgss_pkg::REST_POS)) - $signed({5'b0, cfg.torso_swing});
            end
            cgss_pkg::MODE_FWD_RIGHT, cgss_pkg::MODE_BACK_RIGHT: begin
                gain  = 8'(swing2) + 8'(cfg.turn_swing);
                tbase = $signed(W'(cgss_pkg::REST_POS)) - $signed({5'b0, cfg.torso_swing})
                      - $signed({5'b0, cfg.turn_swing});
            end
            default: begin
                gain  = 8'(swing2);
                tbase = $signed(W'(cgss_pkg::REST_POS)) - $signed({5'b0, cfg.torso_swing});
            end
        endcase
    end

    assign tprod = 16'(gain) * 16'(w0);
    assign tpos  = tbase + $signed({3'b0, tprod[15:8]});

    always_comb begin
        case (mode)
            cgss_pkg::MODE_REST, cgss_pkg::MODE_STAND: torso = 8'(cgss_pkg::REST_POS);
            default:                                    torso = cgss_pkg::clamp_angle(tpos);
        endcase
    end

    assign angles.torso       = torso;
    assign angles.front_left  = limb4;
    assign angles.front_right = 8'(cgss_pkg::FULL_ANGLE) - limb12;
    assign angles.rear_left   = 8'(cgss_pkg::FULL_ANGLE) - limb12;
    assign angles.rear_right  = limb4;

endmodule

// ===== hw/rtl/crawler_gait_servo_sequencer.sv =====
// channel | direction | handshake           | payload
// s_      | in        | s_valid / s_ready   | s_kind, s_command_byte
// m_      | out       | m_valid / m_ready   | five angles, gait_mode, step_period_ms, phase_now
// cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One word per cycle sustained while m_ready stays high. An accepted word updates mode,
// phase and period in the state stage; when the output stage is free, the angles are
// computed from that state and registered there together with m_valid.
// aresetn (synchronous, active low) clears handshake state and loads default config.
// A stalled output holds one result; one more word is held in the state stage,
// after which s_ready drops. cfg_ready is always high.
module crawler_gait_servo_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [7:0]                          s_command_byte,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_torso_angle,
    output logic [7:0]                          m_front_left_angle,
    output logic [7:0]                          m_front_right_angle,
    output logic [7:0]                          m_rear_left_angle,
    output logic [7:0]                          m_rear_right_angle,
    output logic [2:0]                          m_gait_mode,
    output logic [7:0]                          m_step_period_ms,
    output logic [3:0]                          m_phase_now,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cgss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cgss_pkg::CFG_DATA_W-1:0]     cfg_data
);

    cgss_pkg::cfg_t    cfg_reg;
    cgss_pkg::cfg_t    cfg_next;

    cgss_pkg::mode_t   mode_reg;
    cgss_pkg::mode_t   mode_next;
    logic [3:0]        phase_reg;
    logic [3:0]        phase_next;
    logic [7:0]        period_reg;
    logic [7:0]        period_next;
    logic              st_valid_reg;
    logic              st_valid_next;

    logic              m_valid_reg;
    logic              m_valid_next;
    cgss_pkg::angles_t angles_reg;
    logic [2:0]        out_mode_reg;
    logic [7:0]        out_period_reg;
    logic [3:0]        out_phase_reg;

    cgss_pkg::angles_t angles;
    logic              out_free;
    logic              s_fire;
    logic              st_adv;
    logic [3:0]        digit_full;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = !st_valid_reg || out_free;
    assign s_fire    = s_valid && s_ready;
    assign st_adv    = st_valid_reg && out_free;
    assign cfg_ready = 1'b1;

    assign digit_full = 4'(s_command_byte - cgss_pkg::CMD_DIGIT_0);

    always_comb begin
        mode_next   = mode_reg;
        phase_next  = phase_reg;
        period_next = period_reg;
        if (s_fire) begin
            if (!s_kind) begin
                case (s_command_byte)
                    cgss_pkg::CMD_FWD:        mode_next = cgss_pkg::MODE_FWD;
                    cgss_pkg::CMD_BACK:       mode_next = cgss_pkg::MODE_BACK;
                    cgss_pkg::CMD_FWD_LEFT:   mode_next = cgss_pkg::MODE_FWD_LEFT;
                    cgss_pkg::CMD_FWD_RIGHT:  mode_next = cgss_pkg::MODE_FWD_RIGHT;
                    cgss_pkg::CMD_BACK_LEFT:  mode_next = cgss_pkg::MODE_BACK_LEFT;
                    cgss_pkg::CMD_BACK_RIGHT: mode_next = cgss_pkg::MODE_BACK_RIGHT;
                    cgss_pkg::CMD_STAND_L, cgss_pkg::CMD_STAND_R,
                    cgss_pkg::CMD_STAND_S, cgss_pkg::CMD_DIGIT_0:
                                              mode_next = cgss_pkg::MODE_STAND;
                    cgss_pkg::CMD_FAST:       period_next = 8'(cgss_pkg::PERIOD_MIN);
                    default: begin
                        if (s_command_byte >= cgss_pkg::CMD_DIGIT_1 &&
                            s_command_byte <= cgss_pkg::CMD_DIGIT_9) begin
                            // 45 + 15*(10-d) = 195 - 15*d
                            period_next = 8'(cgss_pkg::PERIOD_MIN + cgss_pkg::PERIOD_STEP * 10)
                                        - 8'(cgss_pkg::PERIOD_STEP) * {4'b0, digit_full};
                        end else begin
                            mode_next = cgss_pkg::MODE_REST;
                        end
                    end
                endcase
            end else begin
                case (mode_reg)
                    cgss_pkg::MODE_FWD_LEFT, cgss_pkg::MODE_FWD, cgss_pkg::MODE_FWD_RIGHT:
                        phase_next = phase_reg + 4'd1;
                    cgss_pkg::MODE_BACK_LEFT, cgss_pkg::MODE_BACK, cgss_pkg::MODE_BACK_RIGHT:
                        phase_next = phase_reg - 4'd1;
                    default:
                        phase_next = phase_reg;
                endcase
            end
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cgss_pkg::CFG_STAND_OFFSET: cfg_next.stand_offset = cfg_data;
                cgss_pkg::CFG_TORSO_SWING:  cfg_next.torso_swing  = cfg_data[5:0];
                cgss_pkg::CFG_TURN_SWING:   cfg_next.turn_swing   = cfg_data[5:0];
                cgss_pkg::CFG_STEP_MIN:     cfg_next.step_min     = cfg_data;
                cgss_pkg::CFG_STEP_MAX:     cfg_next.step_max     = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        if (s_fire) begin
            st_valid_next = 1'b1;
        end else if (st_adv) begin
            st_valid_next = 1'b0;
        end else begin
            st_valid_next = st_valid_reg;
        end
        if (st_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    cgss_angle_calc u_angle_calc (
        .cfg    (cfg_reg),
        .mode   (mode_reg),
        .phase  (phase_reg),
        .angles (angles)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stand_offset <= 7'd60;
            cfg_reg.torso_swing  <= 6'd30;
            cfg_reg.turn_swing   <= 6'd30;
            cfg_reg.step_min     <= 7'd10;
            cfg_reg.step_max     <= 7'd80;
            mode_reg             <= cgss_pkg::MODE_REST;
            phase_reg            <= '0;
            period_reg           <= 8'(cgss_pkg::PERIOD_MIN);
            st_valid_reg         <= 1'b0;
            m_valid_reg          <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            mode_reg     <= mode_next;
            phase_reg    <= phase_next;
            period_reg   <= period_next;
            st_valid_reg <= st_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_adv) begin
            angles_reg     <= angles;
            out_mode_reg   <= mode_reg;
            out_period_reg <= period_reg;
            out_phase_reg  <= phase_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_torso_angle       = angles_reg.torso;
    assign m_front_left_angle  = angles_reg.front_left;
    assign m_front_right_angle = angles_reg.front_right;
    assign m_rear_left_angle   = angles_reg.rear_left;
    assign m_rear_right_angle  = angles_reg.rear_right;
    assign m_gait_mode         = out_mode_reg;
    assign m_step_period_ms    = out_period_reg;
    assign m_phase_now         = out_phase_reg;

`ifndef SYNTHESIS
    a_ready_low_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (st_valid_reg && m_valid_reg && !m_ready))
        else $error("s_ready low without both stages full and output stalled");

    a_fwd_tick_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && s_fire && s_kind && (mode_reg == cgss_pkg::MODE_FWD_LEFT ||
         mode_reg == cgss_pkg::MODE_FWD || mode_reg == cgss_pkg::MODE_FWD_RIGHT))
        |=> (phase_reg == $past(phase_reg) + 4'd1))
        else $error("forward tick did not advance phase");

    a_period_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_step_period_ms >= 8'(cgss_pkg::PERIOD_MIN) &&
                     m_step_period_ms <= 8'(cgss_pkg::FULL_ANGLE)))
        else $error("step period out of range");

    a_rest_centered: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_gait_mode == cgss_pkg::MODE_REST) |->
        (m_torso_angle == 8'(cgss_pkg::REST_POS) && m_front_left_angle == 8'(cgss_pkg::REST_POS) &&
         m_front_right_angle == 8'(cgss_pkg::REST_POS) && m_rear_left_angle == 8'(cgss_pkg::REST_POS) &&
         m_rear_right_angle == 8'(cgss_pkg::REST_POS)))
        else $error("rest mode result not centered");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
module tb;

    typedef struct packed {
        logic [7:0]      torso;
        logic [7:0]      front_left;
        logic [7:0]      front_right;
        logic [7:0]      rear_left;
        logic [7:0]      rear_right;
        cgss_pkg::mode_t mode;
        logic [7:0]      period;
        logic [3:0]      phase;
    } servo_word_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  cmd;
        logic        fixed;
        servo_word_t want;
    } script_row_t;

    localparam int STUCK_LIMIT  = 2000;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 203;
    localparam int DRAIN_CYCLES = 4;
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam servo_word_t AT_REST    = '{8'd90, 8'd90, 8'd90, 8'd90, 8'd90,
                                           cgss_pkg::MODE_REST, 8'd45, 4'd0};
    localparam servo_word_t STAND_45   = '{8'd90, 8'd150, 8'd30, 8'd30, 8'd150,
                                           cgss_pkg::MODE_STAND, 8'd45, 4'd0};
    localparam servo_word_t STAND_180  = '{8'd90, 8'd150, 8'd30, 8'd30, 8'd150,
                                           cgss_pkg::MODE_STAND, 8'd180, 4'd0};
    localparam servo_word_t STAND_60   = '{8'd90, 8'd150, 8'd30, 8'd30, 8'd150,
                                           cgss_pkg::MODE_STAND, 8'd60, 4'd0};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = 1'b0;
    logic [7:0]  s_command_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_torso_angle;
    logic [7:0]  m_front_left_angle;
    logic [7:0]  m_front_right_angle;
    logic [7:0]  m_rear_left_angle;
    logic [7:0]  m_rear_right_angle;
    logic [2:0]  m_gait_mode;
    logic [7:0]  m_step_period_ms;
    logic [3:0]  m_phase_now;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [cgss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [cgss_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    always #1 aclk = ~aclk;

    crawler_gait_servo_sequencer uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_kind              (s_kind),
        .s_command_byte      (s_command_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_torso_angle       (m_torso_angle),
        .m_front_left_angle  (m_front_left_angle),
        .m_front_right_angle (m_front_right_angle),
        .m_rear_left_angle   (m_rear_left_angle),
        .m_rear_right_angle  (m_rear_right_angle),
        .m_gait_mode         (m_gait_mode),
        .m_step_period_ms    (m_step_period_ms),
        .m_phase_now         (m_phase_now),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    // gait predictor state
    int              stand_off = 60;
    int              torso_sw = 30;
    int              turn_sw = 30;
    int              lift_min = 10;
    int              lift_max = 80;
    cgss_pkg::mode_t walk_mode = cgss_pkg::MODE_REST;
    logic [3:0]      walk_phase = '0;
    logic [7:0]      step_period = 8'(cgss_pkg::PERIOD_MIN);
    int              gait_wave [16] = '{0, 10, 38, 80, 128, 176, 218, 245,
                                        255, 245, 218, 176, 128, 80, 38, 10};

    logic [7:0] known_commands [11] = '{cgss_pkg::CMD_FWD, cgss_pkg::CMD_BACK,
                                        cgss_pkg::CMD_FWD_LEFT, cgss_pkg::CMD_FWD_RIGHT,
                                        cgss_pkg::CMD_BACK_LEFT, cgss_pkg::CMD_BACK_RIGHT,
                                        cgss_pkg::CMD_STAND_L, cgss_pkg::CMD_STAND_R,
                                        cgss_pkg::CMD_STAND_S, cgss_pkg::CMD_DIGIT_0,
                                        cgss_pkg::CMD_FAST};

    servo_word_t pending_poses [$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          idle_cycles = 0;

    // typed rows hold results that follow directly from the reset settings
    script_row_t opening_script [26] = '{
        '{KIND_TICK, 8'hFF,                    1'b1, AT_REST},
        '{KIND_CMD,  8'h00,                    1'b1, AT_REST},
        '{KIND_CMD,  8'hFF,                    1'b1, AT_REST},
        '{KIND_CMD,  cgss_pkg::CMD_STAND_S,    1'b1, STAND_45},
        '{KIND_TICK, 8'h00,                    1'b1, STAND_45},
        '{KIND_CMD,  cgss_pkg::CMD_STAND_L,    1'b1, STAND_45},
        '{KIND_CMD,  cgss_pkg::CMD_STAND_R,    1'b1, STAND_45},
        '{KIND_CMD,  cgss_pkg::CMD_DIGIT_0,    1'b1, STAND_45},
        '{KIND_CMD,  cgss_pkg::CMD_DIGIT_1,    1'b1, STAND_180},
        '{KIND_CMD,  cgss_pkg::CMD_DIGIT_9,    1'b1, STAND_60},
        '{KIND_CMD,  cgss_pkg::CMD_FAST,       1'b1, STAND_45},
        '{KIND_CMD,  cgss_pkg::CMD_FWD,        1'b0, '0},
        '{KIND_TICK, 8'h55,                    1'b0, '0},
        '{KIND_TICK, 8'hAA,                    1'b0, '0},
        '{KIND_CMD,  cgss_pkg::CMD_BACK,       1'b0, '0},
        '{KIND_TICK, 8'h00,                    1'b0, '0},
        '{KIND_TICK, 8'h00,                    1'b0, '0},
        '{KIND_TICK, 8'h00,                    1'b0, '0},
        '{KIND_CMD,  cgss_pkg::CMD_FWD_LEFT,   1'b0, '0},
        '{KIND_TICK, 8'h00,                    1'b0, '0},
        '{KIND_CMD,  cgss_pkg::CMD_FWD_RIGHT,  1'b0, '0},
        '{KIND_TICK, 8'h00,                    1'b0, '0},
        '{KIND_CMD,  cgss_pkg::CMD_BACK_LEFT,  1'b0, '0},
        '{KIND_TICK, 8'h00,                    1'b0, '0},
        '{KIND_CMD,  cgss_pkg::CMD_BACK_RIGHT, 1'b0, '0},
        '{KIND_TICK, 8'h00,                    1'b0, '0}
    };

    function automatic int sat_angle(int v);
        if (v < 0) return 0;
        if (v > cgss_pkg::FULL_ANGLE) return cgss_pkg::FULL_ANGLE;
        return v;
    endfunction

    function automatic int limb_position(int shift);
        int span;
        int w;
        if (walk_mode == cgss_pkg::MODE_REST) return cgss_pkg::REST_POS;
        if (walk_mode == cgss_pkg::MODE_STAND) return sat_angle(cgss_pkg::REST_POS + stand_off);
        span = lift_max - lift_min;
        if (span < 0) span = 0;
        w = gait_wave[(int'(walk_phase) + shift) % cgss_pkg::PHASE_STEPS];
        return sat_angle(cgss_pkg::REST_POS + lift_min + (span * w) / 256);
    endfunction

    function automatic int torso_position();
        int w;
        w = gait_wave[walk_phase];
        case (walk_mode)
            cgss_pkg::MODE_FWD_LEFT, cgss_pkg::MODE_BACK_LEFT:
                return sat_angle(cgss_pkg::REST_POS - torso_sw
                                 + ((2 * torso_sw + turn_sw) * w) / 256);
            cgss_pkg::MODE_FWD_RIGHT, cgss_pkg::MODE_BACK_RIGHT:
                return sat_angle(cgss_pkg::REST_POS - torso_sw - turn_sw
                                 + ((2 * torso_sw + turn_sw) * w) / 256);
            cgss_pkg::MODE_FWD, cgss_pkg::MODE_BACK:
                return sat_angle(cgss_pkg::REST_POS - torso_sw + ((2 * torso_sw) * w) / 256);
            default:
                return cgss_pkg::REST_POS;
        endcase
    endfunction

    // applies one word to the gait state and returns the pose that follows
    function automatic servo_word_t advance_gait(logic kind, logic [7:0] cmd);
        servo_word_t r;
        if (kind == KIND_CMD) begin
            case (cmd)
                cgss_pkg::CMD_FWD:        walk_mode = cgss_pkg::MODE_FWD;
                cgss_pkg::CMD_BACK:       walk_mode = cgss_pkg::MODE_BACK;
                cgss_pkg::CMD_FWD_LEFT:   walk_mode = cgss_pkg::MODE_FWD_LEFT;
                cgss_pkg::CMD_FWD_RIGHT:  walk_mode = cgss_pkg::MODE_FWD_RIGHT;
                cgss_pkg::CMD_BACK_LEFT:  walk_mode = cgss_pkg::MODE_BACK_LEFT;
                cgss_pkg::CMD_BACK_RIGHT: walk_mode = cgss_pkg::MODE_BACK_RIGHT;
                cgss_pkg::CMD_STAND_L, cgss_pkg::CMD_STAND_R,
                cgss_pkg::CMD_STAND_S, cgss_pkg::CMD_DIGIT_0:
                                          walk_mode = cgss_pkg::MODE_STAND;
                cgss_pkg::CMD_FAST:       step_period = 8'(cgss_pkg::PERIOD_MIN);
                default: begin
                    if (cmd >= cgss_pkg::CMD_DIGIT_1 && cmd <= cgss_pkg::CMD_DIGIT_9) begin
                        step_period = 8'(cgss_pkg::PERIOD_MIN + cgss_pkg::PERIOD_STEP
                                         * (10 - int'(cmd - cgss_pkg::CMD_DIGIT_0)));
                    end else begin
                        walk_mode = cgss_pkg::MODE_REST;
                    end
                end
            endcase
        end else if (walk_mode >= cgss_pkg::MODE_FWD_LEFT &&
                     walk_mode <= cgss_pkg::MODE_FWD_RIGHT) begin
            walk_phase = walk_phase + 4'd1;
        end else if (walk_mode >= cgss_pkg::MODE_BACK_LEFT) begin
            walk_phase = walk_phase - 4'd1;
        end
        r.torso       = 8'(torso_position());
        r.front_left  = 8'(limb_position(4));
        r.front_right = 8'(cgss_pkg::FULL_ANGLE - limb_position(12));
        r.rear_left   = 8'(cgss_pkg::FULL_ANGLE - limb_position(12));
        r.rear_right  = 8'(limb_position(4));
        r.mode        = walk_mode;
        r.period      = step_period;
        r.phase       = walk_phase;
        return r;
    endfunction

    task automatic send_word(input logic kind, input logic [7:0] cmd,
                             input logic fixed, input servo_word_t want);
        servo_word_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_command_byte <= cmd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = advance_gait(kind, cmd);
        pending_poses.push_back(fixed ? want : predicted);
    endtask

    task automatic write_register(input logic [cgss_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [cgss_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            cgss_pkg::CFG_STAND_OFFSET: stand_off = data;
            cgss_pkg::CFG_TORSO_SWING:  torso_sw = data[5:0];
            cgss_pkg::CFG_TURN_SWING:   turn_sw = data[5:0];
            cgss_pkg::CFG_STEP_MIN:     lift_min = data;
            cgss_pkg::CFG_STEP_MAX:     lift_max = data;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_poses.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        servo_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_poses.size() == 0) begin
                $error("result word with nothing expected");
                mismatches++;
            end else begin
                want = pending_poses.pop_front();
                check_field("torso_angle", want.torso, m_torso_angle);
                check_field("front_left_angle", want.front_left, m_front_left_angle);
                check_field("front_right_angle", want.front_right, m_front_right_angle);
                check_field("rear_left_angle", want.rear_left, m_rear_left_angle);
                check_field("rear_right_angle", want.rear_right, m_rear_right_angle);
                check_field("gait_mode", 8'(want.mode), 8'(m_gait_mode));
                check_field("step_period_ms", want.period, m_step_period_ms);
                check_field("phase_now", 8'(want.phase), 8'(m_phase_now));
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STUCK_LIMIT) begin
            $display("crawler_gait_servo_sequencer: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int setting [5];
        int pick;
        logic [7:0] cmd;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (opening_script[i]) begin
            send_word(opening_script[i].kind, opening_script[i].cmd,
                      opening_script[i].fixed, opening_script[i].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // settings change only with the pipeline empty
            s_valid <= 1'b0;
            drain();
            case (ph)
                0: setting = '{60, 30, 30, 10, 80};
                1: setting = '{90, 45, 45, 0, 90};
                2: setting = '{0, 0, 0, 0, 0};
                3: setting = '{127, 127, 127, 127, 127};  // saturates both ways
                4: setting = '{45, 20, 10, 90, 0};        // negative span
                5: setting = '{$urandom_range(0, 90), $urandom_range(0, 45),
                               $urandom_range(0, 45), $urandom_range(0, 90),
                               $urandom_range(0, 90)};
                6: setting = '{$urandom_range(0, 127), $urandom_range(0, 127),
                               $urandom_range(0, 127), $urandom_range(0, 127),
                               $urandom_range(0, 127)};
                default: setting = '{90, 0, 45, 90, 90};
            endcase
            write_register(cgss_pkg::CFG_STAND_OFFSET, 7'(setting[0]));
            write_register(cgss_pkg::CFG_TORSO_SWING, 7'(setting[1]));
            write_register(cgss_pkg::CFG_TURN_SWING, 7'(setting[2]));
            write_register(cgss_pkg::CFG_STEP_MIN, 7'(setting[3]));
            write_register(cgss_pkg::CFG_STEP_MAX, 7'(setting[4]));
            // unmapped index, must not disturb anything
            write_register(cgss_pkg::CFG_IDX_W'($urandom_range(cgss_pkg::CFG_STEP_MAX + 1,
                                                (1 << cgss_pkg::CFG_IDX_W) - 1)),
                           7'($urandom));
            cfg_valid <= 1'b0;

            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 62) begin
                    send_word(KIND_TICK, 8'($urandom), 1'b0, '0);
                end else if (pick < 90) begin
                    pick = $urandom_range(0, 11);
                    cmd = (pick == 11) ? 8'($urandom_range(cgss_pkg::CMD_DIGIT_1,
                                                           cgss_pkg::CMD_DIGIT_9))
                                       : known_commands[pick];
                    send_word(KIND_CMD, cmd, 1'b0, '0);
                end else begin
                    send_word(KIND_CMD, 8'($urandom), 1'b0, '0);
                end
            end
        end

        s_valid <= 1'b0;
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("crawler_gait_servo_sequencer: match");
        end else begin
            $display("crawler_gait_servo_sequencer: mismatch");
        end
        $finish;
    end

endmodule
